### hw/rtl/rfm_pkg.sv
// ----------------------------------------------------------------------------
// rfm_pkg
// Shared constants, register codes and controller/datapath types for the
// rms and frequency meter.
// ----------------------------------------------------------------------------
package rfm_pkg;

  // build constants
  localparam int SAMPLE_BITS = 12;
  localparam int MAX_WINDOW  = 1024;

  // field widths
  localparam int SAMPLE_W   = 12;
  localparam int OFFSET_W   = 12;
  localparam int SCALE_W    = 20;
  localparam int WLEN_W     = 11;
  localparam int PERIOD_W   = 16;
  localparam int RATE_W     = 16;
  localparam int RMS_W      = 17;
  localparam int FREQ_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = OFFSET_W'(1497);
  localparam logic [SCALE_W-1:0]  SCALE_RST    = SCALE_W'(8579);
  localparam logic [WLEN_W-1:0]   WLEN_RST     = WLEN_W'(333);
  localparam logic [PERIOD_W-1:0] MINPER_RST   = PERIOD_W'(250);
  localparam logic [RATE_W-1:0]   RATE_RST     = RATE_W'(20000);
  localparam logic [RMS_W-1:0]    BLACKOUT_RST = RMS_W'(16896);
  localparam logic [FREQ_W-1:0]   FREQ_RST     = FREQ_W'(15360);

  // sample masking and difference
  localparam logic [SAMPLE_W-1:0] SMASK =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam int DIFF_W = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * MAG_W;

  // window
  localparam int WIN_IDX_W = $clog2(MAX_WINDOW);
  localparam int N_W       = WIN_IDX_W + 1;
  localparam int N_CMP_W   = (WLEN_W > N_W) ? WLEN_W : N_W;

  // accumulation, division and square root
  localparam int SUM_W     = 36;
  localparam int FRAC_W    = 16;
  localparam int MDIV_W    = SUM_W + FRAC_W;
  localparam int ROOT_W    = MDIV_W / 2;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int DSR_W     = PERIOD_W;
  localparam int FREQ_FRAC = 8;
  localparam int FNUM_W    = RATE_W + FREQ_FRAC + 1;
  localparam int PROD_W    = ROOT_W + SCALE_W;
  localparam int ROUND_W   = PROD_W + 1;

  localparam int FDIV_STEPS = FNUM_W;
  localparam int MDIV_STEPS = MDIV_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(MDIV_W + 1);

  localparam longint RMS_MAX  = (64'd1 << RMS_W) - 1;
  localparam longint FREQ_MAX = (64'd1 << FREQ_W) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET   = 3'd0,
    REG_SCALE    = 3'd1,
    REG_WLEN     = 3'd2,
    REG_MINPER   = 3'd3,
    REG_RATE     = 3'd4,
    REG_BLACKOUT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FDIV,
    ST_FSTORE,
    ST_MLOAD,
    ST_MDIV,
    ST_SQLOAD,
    ST_SQRT,
    ST_MUL,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic fdiv_load;
    logic mdiv_load;
    logic div_step;
    logic fstore;
    logic sqrt_load;
    logic sqrt_step;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic crossing;
    logic win_end;
  } dp_stat_t;

endpackage

### hw/rtl/rfm_if.sv
// ----------------------------------------------------------------------------
// rfm_if
// Valid/ready channels of the rms and frequency meter: sample input,
// result output and register write.
// ----------------------------------------------------------------------------
interface rfm_in_if;
  logic                           valid;
  logic                           ready;
  logic [rfm_pkg::SAMPLE_W-1:0]   sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface rfm_out_if;
  logic                         valid;
  logic                         ready;
  logic [rfm_pkg::RMS_W-1:0]    rms_volts;
  logic [rfm_pkg::FREQ_W-1:0]   frequency;
  logic                         blackout;

  modport source (output valid, output rms_volts, output frequency, output blackout,
                  input ready);
  modport sink   (input valid, input rms_volts, input frequency, input blackout,
                  output ready);
endinterface

interface rfm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rfm_pkg::CFG_IDX_W-1:0]    index;
  logic [rfm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rfm_ctrl.sv
// ----------------------------------------------------------------------------
// rfm_ctrl
// Sequencer of the meter: takes one item, runs the update, the frequency
// divide on a crossing and, at a window end, the mean divide, the square root
// and the scaling, and loads the result register.
// ----------------------------------------------------------------------------
module rfm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  rfm_pkg::dp_stat_t stat,
  output rfm_pkg::dp_cmd_t  cmd
);
  import rfm_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              win_end_r, win_end_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      win_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      win_end_r   <= win_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    win_end_nxt = win_end_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval    = 1'b1;
        win_end_nxt = stat.win_end;
        if (stat.crossing) begin
          cmd.fdiv_load = 1'b1;
          state_nxt     = ST_FDIV;
        end else if (stat.win_end) begin
          state_nxt = ST_MLOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(FDIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FSTORE;
        end
      end
      ST_FSTORE: begin
        cmd.fstore = 1'b1;
        state_nxt  = win_end_r ? ST_MLOAD : ST_IDLE;
      end
      ST_MLOAD: begin
        cmd.mdiv_load = 1'b1;
        state_nxt     = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MDIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQLOAD;
        end
      end
      ST_SQLOAD: begin
        cmd.sqrt_load = 1'b1;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/rfm_datapath.sv
// ----------------------------------------------------------------------------
// rfm_datapath
// Registers, sample update, shared restoring divider, two-bit-per-step
// square root, scaling multiplier and result register of the meter.
// ----------------------------------------------------------------------------
module rfm_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rfm_pkg::cfg_wr_t               cfg_wr,
  input  logic [rfm_pkg::SAMPLE_W-1:0]   in_sample_mv,
  input  rfm_pkg::dp_cmd_t               cmd,
  output rfm_pkg::dp_stat_t              stat,
  output logic [rfm_pkg::RMS_W-1:0]      out_rms_volts,
  output logic [rfm_pkg::FREQ_W-1:0]     out_frequency,
  output logic                           out_blackout
);
  import rfm_pkg::*;

  // configuration
  logic [OFFSET_W-1:0] offset_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [WLEN_W-1:0]   wlen_r;
  logic [PERIOD_W-1:0] min_period_r;
  logic [RATE_W-1:0]   rate_r;
  logic [RMS_W-1:0]    blackout_lvl_r;

  // running state
  logic [SUM_W-1:0]     sum_r;
  logic [WIN_IDX_W-1:0] win_idx_r;
  logic [PERIOD_W-1:0]  period_r;
  logic                 last_np_r;
  logic [FREQ_W-1:0]    freq_r;

  // payload
  logic [SAMPLE_W-1:0] sample_r;
  logic [DSR_W:0]      div_rem_r;
  logic [MDIV_W-1:0]   div_q_r;
  logic [DSR_W-1:0]    div_dsr_r;
  logic [MDIV_W-1:0]   rad_r;
  logic [SREM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [PROD_W-1:0]   prod_r;
  logic [RMS_W-1:0]    out_rms_r;
  logic [FREQ_W-1:0]   out_freq_r;
  logic                out_blk_r;

  // sample update
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_neg;
  logic                     positive;
  logic [MAG_W-1:0]         mag;
  logic [SQ_W-1:0]          sq;
  logic [PERIOD_W-1:0]      cnt_inc;
  logic                     crossing;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W-1:0]         sum_sat;
  logic [N_W-1:0]           n;
  logic [N_W-1:0]           idx_inc;
  logic                     win_end;
  logic [FNUM_W-1:0]        fnum;

  // iteration steps
  logic [DSR_W:0]      div_shift;
  logic                div_ge;
  logic [SREM_W+1:0]   sq_shift;
  logic [SREM_W+1:0]   sq_trial;
  logic [SREM_W+1:0]   sq_diff;
  logic                sq_ge;
  logic [FNUM_W-1:0]   fq;
  logic [ROUND_W-1:0]  rnd;
  logic [ROUND_W-FRAC_W-1:0] rms_wide;
  logic [RMS_W-1:0]    rms;

  always_comb begin
    diff     = $signed(DIFF_W'(sample_r)) - $signed(DIFF_W'(offset_r));
    diff_neg = -diff;
    positive = !diff[DIFF_W-1] && (diff != '0);
    mag      = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    sq       = SQ_W'(mag) * SQ_W'(mag);

    cnt_inc  = (period_r == '1) ? period_r : period_r + 1'b1;
    crossing = last_np_r && positive && (cnt_inc > min_period_r);

    sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(sq);
    sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    if (wlen_r == '0) begin
      n = N_W'(1);
    end else if (N_CMP_W'(wlen_r) > N_CMP_W'(MAX_WINDOW)) begin
      n = N_W'(MAX_WINDOW);
    end else begin
      n = N_W'(wlen_r);
    end
    idx_inc = N_W'(win_idx_r) + 1'b1;
    win_end = idx_inc >= n;

    fnum = FNUM_W'({rate_r, {FREQ_FRAC{1'b0}}}) + FNUM_W'(cnt_inc >> 1);

    div_shift = {div_rem_r[DSR_W-1:0], div_q_r[MDIV_W-1]};
    div_ge    = div_shift >= {1'b0, div_dsr_r};

    sq_shift = {srem_r, rad_r[MDIV_W-1 -: 2]};
    sq_trial = (SREM_W + 2)'({root_r, 2'b01});
    sq_ge    = sq_shift >= sq_trial;
    sq_diff  = sq_shift - sq_trial;

    fq = div_q_r[FNUM_W-1:0];

    rnd      = {1'b0, prod_r} + ROUND_W'(64'd1 << (FRAC_W - 1));
    rms_wide = rnd[ROUND_W-1:FRAC_W];
    rms      = (rms_wide > (ROUND_W - FRAC_W)'(RMS_MAX)) ? RMS_W'(RMS_MAX)
                                                         : rms_wide[RMS_W-1:0];
  end

  assign stat.crossing = crossing;
  assign stat.win_end  = win_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r       <= OFFSET_RST;
      scale_r        <= SCALE_RST;
      wlen_r         <= WLEN_RST;
      min_period_r   <= MINPER_RST;
      rate_r         <= RATE_RST;
      blackout_lvl_r <= BLACKOUT_RST;
    end else if (cfg_wr.we) begin
      unique case (cfg_reg_t'(cfg_wr.idx))
        REG_OFFSET:   offset_r       <= cfg_wr.data[OFFSET_W-1:0];
        REG_SCALE:    scale_r        <= cfg_wr.data[SCALE_W-1:0];
        REG_WLEN:     wlen_r         <= cfg_wr.data[WLEN_W-1:0];
        REG_MINPER:   min_period_r   <= cfg_wr.data[PERIOD_W-1:0];
        REG_RATE:     rate_r         <= cfg_wr.data[RATE_W-1:0];
        REG_BLACKOUT: blackout_lvl_r <= cfg_wr.data[RMS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      win_idx_r <= '0;
      period_r  <= '0;
      last_np_r <= 1'b1;
      freq_r    <= FREQ_RST;
    end else begin
      if (cmd.eval) begin
        period_r  <= crossing ? '0 : cnt_inc;
        last_np_r <= !positive;
        sum_r     <= sum_sat;
        win_idx_r <= win_end ? '0 : idx_inc[WIN_IDX_W-1:0];
      end
      if (cmd.mdiv_load) begin
        sum_r <= '0;
      end
      if (cmd.fstore) begin
        freq_r <= (fq > FNUM_W'(FREQ_MAX)) ? FREQ_W'(FREQ_MAX) : fq[FREQ_W-1:0];
      end
    end
  end

  // sample, divider, square root, multiplier and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample_mv & SMASK;
    end

    if (cmd.fdiv_load) begin
      div_rem_r <= '0;
      div_q_r   <= {fnum, (MDIV_W - FNUM_W)'(0)};
      div_dsr_r <= cnt_inc;
    end else if (cmd.mdiv_load) begin
      div_rem_r <= '0;
      div_q_r   <= {sum_r, FRAC_W'(0)};
      div_dsr_r <= DSR_W'(n);
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_shift - {1'b0, div_dsr_r} : div_shift;
      div_q_r   <= {div_q_r[MDIV_W-2:0], div_ge};
    end

    if (cmd.sqrt_load) begin
      rad_r  <= div_q_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= rad_r << 2;
      srem_r <= sq_ge ? sq_diff[SREM_W-1:0] : sq_shift[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], sq_ge};
    end

    if (cmd.mul) begin
      prod_r <= PROD_W'(root_r) * PROD_W'(scale_r);
    end

    if (cmd.out_load) begin
      out_rms_r  <= rms;
      out_freq_r <= freq_r;
      out_blk_r  <= rms <= blackout_lvl_r;
    end
  end

  assign out_rms_volts = out_rms_r;
  assign out_frequency = out_freq_r;
  assign out_blackout  = out_blk_r;

endmodule

### hw/rtl/rms_frequency_meter.sv
// ----------------------------------------------------------------------------
// rms_frequency_meter
// An item that closes no window is captured and evaluated; an accepted rising
// crossing adds a 25-step divide in the shared divider and a store.
// An item that closes a window then runs a 52-step mean divide, a 26-step
// square root and a multiply, and waits for a free result register.
// One item is in work at a time; the result register frees the input side.
// Synchronous active-low reset restores register defaults and idles the block.
// ----------------------------------------------------------------------------
module rms_frequency_meter (
  input  logic       clk,
  input  logic       rst_n,
  rfm_in_if.sink     in_ch,
  rfm_out_if.source  out_ch,
  rfm_cfg_if.sink    cfg_ch
);
  import rfm_pkg::*;

  cfg_wr_t  cfg_wr;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  rfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .in_sample_mv  (in_ch.sample_mv),
    .cmd           (cmd),
    .stat          (stat),
    .out_rms_volts (out_ch.rms_volts),
    .out_frequency (out_ch.frequency),
    .out_blackout  (out_ch.blackout)
  );

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while previous item still in work");

  // result register never overwritten while holding an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register loaded while full");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && in_ch.ready))
    else $error("block not idle after reset");

endmodule

### tb/rms_frequency_meter_test.sv
// ----------------------------------------------------------------------------
// rms_frequency_meter_test
// Self-checking bench for the rms and frequency meter. A queue-fed driver
// offers samples over the input channel and predicts each window result the
// moment a sample is accepted. The monitor compares every result field by
// field against the oldest prediction. Both sides insert random gaps, and the
// result side holds off once for a long stretch so the meter backs up. The
// run covers directed extremes, register setups at their limits, a window
// shrunk partway through, random square waves with noise, and a window above
// the maximum length run without gaps at the end.
// ----------------------------------------------------------------------------
module rms_frequency_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfm_pkg::*;

  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 800;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int WIDE_ITEMS    = 1030;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;
  localparam longint unsigned SQ_SUM_MAX = (64'd1 << SUM_W) - 1;

  typedef struct packed {
    logic [RMS_W-1:0]  rms_volts;
    logic [FREQ_W-1:0] frequency;
    logic              blackout;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  rfm_in_if  in_ch();
  rfm_out_if out_ch();
  rfm_cfg_if cfg_ch();

  rms_frequency_meter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register shadow
  logic [OFFSET_W-1:0] cfg_offset   = OFFSET_RST;
  logic [SCALE_W-1:0]  cfg_scale    = SCALE_RST;
  logic [WLEN_W-1:0]   cfg_wlen     = WLEN_RST;
  logic [PERIOD_W-1:0] cfg_min_per  = MINPER_RST;
  logic [RATE_W-1:0]   cfg_rate     = RATE_RST;
  logic [RMS_W-1:0]    cfg_blackout = BLACKOUT_RST;

  // meter state
  longint unsigned     square_sum    = 0;
  int unsigned         win_pos       = 0;
  logic [PERIOD_W-1:0] period_count  = '0;
  bit                  below_zero    = 1'b1;
  logic [FREQ_W-1:0]   freq_estimate = FREQ_RST;

  reading_t            reading_q[$];
  logic [SAMPLE_W-1:0] sample_q[$];
  int                  queued_total   = 0;
  int                  accepted_total = 0;
  int                  mismatches     = 0;
  int                  send_gap       = 0;
  int                  recv_gap       = 0;
  bit                  idle_on        = 1'b1;
  bit                  hold_armed     = 1'b0;
  logic                long_hold      = 1'b0;

  function automatic void meter_predict(input logic [SAMPLE_W-1:0] sample);
    int              diff;
    int              mag;
    int              b;
    int unsigned     span;
    longint unsigned sq;
    longint unsigned quot;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned scaled;
    reading_t        res;
    diff = int'(sample & SMASK) - int'(cfg_offset);
    mag  = (diff < 0) ? -diff : diff;
    sq   = longint'(mag) * longint'(mag);
    if (period_count != '1) period_count = period_count + 1'b1;
    if (below_zero && diff > 0 && period_count > cfg_min_per) begin
      quot = (longint'(cfg_rate) * 256 + period_count / 2) / period_count;
      freq_estimate = (quot > FREQ_MAX) ? FREQ_W'(FREQ_MAX) : FREQ_W'(quot);
      period_count = '0;
    end
    below_zero = !(diff > 0);
    if (square_sum > SQ_SUM_MAX - sq) square_sum = SQ_SUM_MAX;
    else square_sum = square_sum + sq;
    span = cfg_wlen;
    if (span == 0) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    if (win_pos + 1 >= span) begin
      mean = (square_sum << FRAC_W) / span;
      root = 0;
      for (b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= mean) root = trial;
      end
      scaled = (root * cfg_scale + 32768) >> 16;
      res.rms_volts = (scaled > RMS_MAX) ? RMS_W'(RMS_MAX) : RMS_W'(scaled);
      res.frequency = freq_estimate;
      res.blackout  = (res.rms_volts <= cfg_blackout);
      reading_q.push_back(res);
      square_sum = 0;
      win_pos    = 0;
    end else begin
      win_pos++;
    end
  endfunction

  function automatic void report_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        meter_predict(in_ch.sample_mv);
        accepted_total++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid     <= 1'b1;
          in_ch.sample_mv <= sample_q.pop_front();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reading_q.size() == 0) begin
          report_mismatch("unexpected item", 0, out_ch.rms_volts);
        end else begin
          want = reading_q.pop_front();
          if (out_ch.rms_volts !== want.rms_volts)
            report_mismatch("rms_volts", want.rms_volts, out_ch.rms_volts);
          if (out_ch.frequency !== want.frequency)
            report_mismatch("frequency", want.frequency, out_ch.frequency);
          if (out_ch.blackout !== want.blackout)
            report_mismatch("blackout", want.blackout, out_ch.blackout);
        end
      end
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long result-side hold-off
  initial begin
    wait (hold_armed == 1'b1);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #2_400_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_OFFSET:   cfg_offset   = OFFSET_W'(value);
      REG_SCALE:    cfg_scale    = SCALE_W'(value);
      REG_WLEN:     cfg_wlen     = WLEN_W'(value);
      REG_MINPER:   cfg_min_per  = PERIOD_W'(value);
      REG_RATE:     cfg_rate     = RATE_W'(value);
      REG_BLACKOUT: cfg_blackout = RMS_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int unsigned offset, input int unsigned scale,
                             input int unsigned wlen, input int unsigned min_per,
                             input int unsigned rate, input int unsigned blackout);
    write_reg(REG_OFFSET, offset);
    write_reg(REG_SCALE, scale);
    write_reg(REG_WLEN, wlen);
    write_reg(REG_MINPER, min_per);
    write_reg(REG_RATE, rate);
    write_reg(REG_BLACKOUT, blackout);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_sample(input int value);
    if (value < 0) value = 0;
    else if (value > SAMPLE_TOP) value = SAMPLE_TOP;
    sample_q.push_back(SAMPLE_W'(value));
    queued_total++;
  endtask

  // square wave bursts around the offset with noise, plus random samples
  task automatic add_mixed(input int total);
    int added;
    int len;
    int period;
    int amp;
    int noise;
    int level;
    int k;
    added = 0;
    while (added < total) begin
      if ($urandom_range(0, 9) < 8) begin
        period = $urandom_range(4, 80);
        amp    = $urandom_range(0, 2047);
        noise  = $urandom_range(0, 40);
        len    = $urandom_range(period, 4 * period);
        if (len > total - added) len = total - added;
        for (k = 0; k < len; k++) begin
          level = ((k % period) < period / 2) ? amp : -amp;
          queue_sample(int'(cfg_offset) + level + int'($urandom_range(0, 2 * noise)) - noise);
        end
      end else begin
        len = $urandom_range(1, 8);
        if (len > total - added) len = total - added;
        for (k = 0; k < len; k++) queue_sample($urandom_range(0, SAMPLE_TOP));
      end
      added += len;
    end
  endtask

  task automatic finish_phase();
    while (accepted_total != queued_total || reading_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int edge_a[$] = '{0, 4095, 2048, 2049, 2047, 2049, 4095, 1, 2048, 4094};
    int edge_b[$] = '{0, 3, 0, 0, 9, 4095};
    int edge_c[$] = '{0, 4095, 0, 4095, 4095, 0};
    int ph;
    int k;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_mv = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_OFFSET;
    cfg_ch.data     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one result per item, every rising edge accepted
    apply_setup(2048, 8579, 1, 0, 65535, 131071);
    foreach (edge_a[k]) queue_sample(edge_a[k]);
    finish_phase();

    // zero window acts as one, zero scale, zero rate
    apply_setup(0, 0, 0, 1, 0, 0);
    foreach (edge_b[k]) queue_sample(edge_b[k]);
    finish_phase();

    // full scale saturates rms, crossings never accepted
    apply_setup(1000, 1048575, 2, 65535, 1, 65536);
    foreach (edge_c[k]) queue_sample(edge_c[k]);
    finish_phase();

    // window shrunk partway through
    apply_setup(2000, 8579, 2047, 5, 20000, 16896);
    for (k = 0; k < 5; k++) queue_sample($urandom_range(0, SAMPLE_TOP));
    finish_phase();
    write_reg(REG_WLEN, 3);
    cfg_ch.valid <= 1'b0;
    queue_sample(2500);
    finish_phase();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        apply_setup($urandom_range(1500, 2500), $urandom_range(1, 20000), 1,
                    $urandom_range(0, 20), $urandom_range(1, 65535),
                    $urandom_range(0, 70000));
        hold_armed = 1'b1;
      end else if (ph == 1) begin
        apply_setup(4095, $urandom_range(1, 1048575), $urandom_range(1, 64),
                    $urandom_range(0, 40), $urandom_range(1, 65535),
                    $urandom_range(0, 131071));
      end else begin
        apply_setup($urandom_range(1200, 2800), $urandom_range(1, 20000),
                    $urandom_range(1, 64), $urandom_range(0, 40),
                    $urandom_range(1, 65535), $urandom_range(0, 70000));
      end
      add_mixed(PHASE_ITEMS);
      finish_phase();
    end

    // window length above the maximum, no gaps
    idle_on = 1'b0;
    apply_setup($urandom_range(1500, 2500), $urandom_range(1, 20000), 2047,
                $urandom_range(0, 40), $urandom_range(1, 65535), $urandom_range(0, 70000));
    add_mixed(WIDE_ITEMS);
    finish_phase();

    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
